/* hw/rtl/cal_pkg.sv */
package cal_pkg;

   localparam int SOURCE_ENTRIES = 64;
   localparam int IDX_W          = $clog2(SOURCE_ENTRIES);
   localparam int ADDR_W         = 32;
   localparam int COUNT_W        = 16;
   localparam int TOTAL_W        = 17;
   localparam int ENTRY_W        = ADDR_W + COUNT_W;
   localparam int CSR_INDEX_W    = 1;

   localparam logic [TOTAL_W-1:0] GLOBAL_MAX = {TOTAL_W{1'b1}};
   localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};

   localparam logic [CSR_INDEX_W-1:0] REG_MAX_TOTAL      = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_PER_SOURCE = 1'b1;

   localparam logic KIND_OPEN  = 1'b0;
   localparam logic KIND_CLOSE = 1'b1;

   typedef struct packed {
      logic              kind;
      logic [ADDR_W-1:0] source_address;
      logic              has_context;
   } req_type;

   typedef struct packed {
      logic               admitted;
      logic               table_full;
      logic [TOTAL_W-1:0] total_open;
   } rsp_type;

   typedef struct packed {
      logic [COUNT_W-1:0] max_total;
      logic [COUNT_W-1:0] max_per_source;
   } cfg_type;

endpackage

/* hw/rtl/cal_entry_ram.sv */
module cal_entry_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/cal_ctrl.sv */
module cal_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  cal_pkg::req_type                  req,
   output logic                              rsp_valid,
   output cal_pkg::rsp_type                  rsp,
   input  cal_pkg::cfg_type                  cfg,
   output logic                              ram_wr_en,
   output logic [cal_pkg::IDX_W-1:0]         ram_wr_addr,
   output logic [cal_pkg::ENTRY_W-1:0]       ram_wr_data,
   output logic [cal_pkg::IDX_W-1:0]         ram_rd_addr,
   input  logic [cal_pkg::ENTRY_W-1:0]       ram_rd_data
);
   import cal_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_EVAL   = 4'b0010,
      S_SCAN   = 4'b0100,
      S_UPDATE = 4'b1000
   } state_type;

   state_type                 state_ff, state_in;
   req_type                   item_ff, item_in;
   logic [TOTAL_W-1:0]        gc_ff, gc_in;
   logic [SOURCE_ENTRIES-1:0] valid_ff, valid_in;
   logic [IDX_W:0]            issue_ff, issue_in;
   logic                      cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]          cmp_idx_ff, cmp_idx_in;
   logic                      free_ok_ff, free_ok_in;
   logic [IDX_W-1:0]          free_idx_ff, free_idx_in;
   logic                      hit_ff, hit_in;
   logic [IDX_W-1:0]          hit_idx_ff, hit_idx_in;
   logic [COUNT_W-1:0]        hit_cnt_ff, hit_cnt_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_ff, rsp_in;

   logic [ADDR_W-1:0]  rd_addr_field;
   logic [COUNT_W-1:0] rd_cnt_field;
   logic [TOTAL_W-1:0] gc_up;
   logic [COUNT_W-1:0] cnt_next;
   logic               cmp_hit;
   logic               accept;

   assign rd_addr_field = ram_rd_data[ENTRY_W-1 -: ADDR_W];
   assign rd_cnt_field  = ram_rd_data[COUNT_W-1:0];
   assign gc_up         = (gc_ff < GLOBAL_MAX) ? gc_ff + 1'b1 : gc_ff;
   assign accept        = start && !busy;
   assign ram_rd_addr   = issue_ff[IDX_W-1:0];

   // shared compare: stored address against the item's source
   assign cmp_hit = cmp_vld_ff && valid_ff[cmp_idx_ff]
                    && (rd_addr_field == item_ff.source_address);

   // saturating step of the selected source counter
   always_comb begin
      if (item_ff.kind == KIND_OPEN) begin
         cnt_next = (hit_cnt_ff < COUNT_MAX) ? hit_cnt_ff + 1'b1 : hit_cnt_ff;
      end else begin
         cnt_next = (hit_cnt_ff != '0) ? hit_cnt_ff - 1'b1 : hit_cnt_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      gc_in        = gc_ff;
      valid_in     = valid_ff;
      issue_in     = issue_ff;
      cmp_vld_in   = 1'b0;
      cmp_idx_in   = issue_ff[IDX_W-1:0];
      free_ok_in   = free_ok_ff;
      free_idx_in  = free_idx_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_cnt_in   = hit_cnt_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = hit_idx_ff;
      ram_wr_data  = {item_ff.source_address, cnt_next};

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               item_in  = req;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            issue_in   = '0;
            free_ok_in = 1'b0;
            hit_in     = 1'b0;
            if (item_ff.kind == KIND_OPEN) begin
               gc_in = gc_up;
               if (gc_up > {1'b0, cfg.max_total}) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{admitted: 1'b0, table_full: 1'b0, total_open: gc_up};
                  state_in     = S_IDLE;
               end else if (cfg.max_per_source == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{admitted: 1'b1, table_full: 1'b0, total_open: gc_up};
                  state_in     = S_IDLE;
               end else begin
                  state_in = S_SCAN;
               end
            end else if (item_ff.has_context) begin
               gc_in = (gc_ff != '0) ? gc_ff - 1'b1 : gc_ff;
               if (cfg.max_per_source == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{admitted: 1'b0, table_full: 1'b0, total_open: gc_in};
                  state_in     = S_IDLE;
               end else begin
                  state_in = S_SCAN;
               end
            end else begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{admitted: 1'b0, table_full: 1'b0, total_open: gc_ff};
               state_in     = S_IDLE;
            end
         end
         S_SCAN: begin
            if (issue_ff < (IDX_W+1)'(SOURCE_ENTRIES)) begin
               issue_in   = issue_ff + 1'b1;
               cmp_vld_in = 1'b1;
            end
            if (cmp_hit) begin
               hit_in     = 1'b1;
               hit_idx_in = cmp_idx_ff;
               hit_cnt_in = rd_cnt_field;
               state_in   = S_UPDATE;
            end else if (cmp_vld_ff) begin
               if (!valid_ff[cmp_idx_ff] && !free_ok_ff) begin
                  free_ok_in  = 1'b1;
                  free_idx_in = cmp_idx_ff;
               end
               if (cmp_idx_ff == IDX_W'(SOURCE_ENTRIES - 1)) begin
                  state_in = S_UPDATE;
               end
            end
         end
         S_UPDATE: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
            rsp_in       = '{admitted: 1'b0, table_full: 1'b0, total_open: gc_ff};
            if (item_ff.kind == KIND_OPEN) begin
               if (hit_ff) begin
                  ram_wr_en       = 1'b1;
                  rsp_in.admitted = (cnt_next <= cfg.max_per_source);
               end else if (free_ok_ff) begin
                  ram_wr_en             = 1'b1;
                  ram_wr_addr           = free_idx_ff;
                  ram_wr_data           = {item_ff.source_address, COUNT_W'(1)};
                  valid_in[free_idx_ff] = 1'b1;
                  rsp_in.admitted       = 1'b1;
               end else begin
                  rsp_in.table_full = 1'b1;
               end
            end else if (hit_ff) begin
               ram_wr_en = 1'b1;
               if (cnt_next == '0) begin
                  valid_in[hit_idx_ff] = 1'b0;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         gc_ff        <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         cmp_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gc_ff        <= gc_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cmp_vld_ff   <= cmp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      issue_ff    <= issue_in;
      cmp_idx_ff  <= cmp_idx_in;
      free_ok_ff  <= free_ok_in;
      free_idx_ff <= free_idx_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      hit_cnt_ff  <= hit_cnt_in;
      rsp_ff      <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

/* hw/rtl/connection_admission_limiter_unit.sv */
// channel   direction  handshake                 word
// req_      in         start high, busy low      kind, source_address, has_context
// rsp_      out        rsp_valid, one cycle      admitted, table_full, total_open
// csr_      in         csr_valid and csr_ready   csr_index, csr_data
//
// an item that skips the source table (global reject, per-source limit off, close
// without context) shows its word straight from the evaluate state; one that walks the
// table reads one entry of the entry ram per cycle until its source is found or the
// last entry is compared, then updates the entry and shows its word
// busy drops in the cycle the word is shown, so the next start can follow at once
// reset clears the global count and valid bits at once; the receiver cannot stall
module connection_admission_limiter_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  cal_pkg::req_type                 req,
   output logic                             rsp_valid,
   output cal_pkg::rsp_type                 rsp,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [cal_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [cal_pkg::COUNT_W-1:0]      csr_data
);
   import cal_pkg::*;

   cfg_type              cfg_ff, cfg_in;
   logic                 ram_wr_en;
   logic [IDX_W-1:0]     ram_wr_addr;
   logic [ENTRY_W-1:0]   ram_wr_data;
   logic [IDX_W-1:0]     ram_rd_addr;
   logic [ENTRY_W-1:0]   ram_rd_data;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_MAX_TOTAL:      cfg_in.max_total      = csr_data;
            REG_MAX_PER_SOURCE: cfg_in.max_per_source = csr_data;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_total      <= COUNT_MAX;
         cfg_ff.max_per_source <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cal_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req         (req),
      .rsp_valid   (rsp_valid),
      .rsp         (rsp),
      .cfg         (cfg_ff),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   cal_entry_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SOURCE_ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

/* hw/rtl/cal_checker.sv */
module cal_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input cal_pkg::rsp_type rsp
);
   import cal_pkg::*;

   // a word follows only work in progress
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> $past(busy))
      else $error("word shown without an item in progress");

   assert property (@(posedge clock) disable iff (reset) (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   // busy ends exactly when the word is shown
   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(busy)) |-> rsp_valid)
      else $error("busy dropped without a word");

   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !rsp_valid)
      else $error("two words for one item");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp.admitted && rsp.table_full))
      else $error("admitted open flagged table full");

endmodule

bind connection_admission_limiter_unit cal_checker u_cal_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp       (rsp)
);
